>>> rtl/lzpid_pkg.sv
// shared types and constants for the paged lz image decoder
`default_nettype none

package lzpid_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned LenW      = 9;
  localparam int unsigned TdataW    = 56;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // result kinds
  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_COPY = 2'd1,
    KIND_END  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  // parser phases, one-hot
  typedef enum logic [15:0] {
    PH_MAGIC0 = 16'h0001,
    PH_MAGIC1 = 16'h0002,
    PH_SEGHI  = 16'h0004,
    PH_SEGLO  = 16'h0008,
    PH_TOKEN  = 16'h0010,
    PH_LITCNT = 16'h0020,
    PH_LITS   = 16'h0040,
    PH_MCNT   = 16'h0080,
    PH_OFFHI  = 16'h0100,
    PH_OFFLO  = 16'h0200,
    PH_LSEGHI = 16'h0400,
    PH_LSEGLO = 16'h0800,
    PH_EXECHI = 16'h1000,
    PH_EXECLO = 16'h2000,
    PH_DONE   = 16'h4000,
    PH_ERROR  = 16'h8000
  } phase_e;

  typedef struct packed {
    kind_e              kind;
    logic [AddrW-1:0]   dest;
    logic [DataW-1:0]   data;
    logic [AddrW-1:0]   src;
    logic [LenW-1:0]    len;
    logic               reloc;
    logic               last;
  } result_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_t;

  typedef struct packed {
    logic [FifoCntW-1:0] count;
  } fifo_status_t;

endpackage

`default_nettype wire

>>> rtl/lzpid_parser.sv
// byte parser: phase registers and the per-byte token step
`default_nettype none

module lzpid_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic [lzpid_pkg::DataW-1:0]   byte_i,
  input  wire logic                          start_i,
  output lzpid_pkg::step_t                   step_o
);
  import lzpid_pkg::*;

  phase_e           phase_q, phase_d, cur_phase;
  logic [AddrW-1:0] waddr_q, waddr_d, cur_waddr;
  logic [AddrW-1:0] seg_q, seg_d, cur_seg;
  logic [AddrW-1:0] off_q, off_d, cur_off;
  logic [DataW-1:0] tok_q, tok_d, cur_tok;
  logic [LenW-1:0]  left_q, left_d, cur_left;
  logic [LenW-1:0]  idx_q, idx_d, cur_idx;
  logic [LenW-1:0]  mlen_q, mlen_d, cur_mlen;
  logic [DataW-1:0] hib_q, hib_d, cur_hib;
  logic             reloc_q, reloc_d, cur_reloc;

  // a start byte sees the reset state
  always_comb begin
    if (start_i) begin
      cur_phase = PH_MAGIC0;
      cur_waddr = '0;
      cur_seg   = '0;
      cur_off   = AddrW'(1);
      cur_tok   = '0;
      cur_left  = '0;
      cur_idx   = '0;
      cur_mlen  = '0;
      cur_hib   = '0;
      cur_reloc = 1'b1;
    end else begin
      cur_phase = phase_q;
      cur_waddr = waddr_q;
      cur_seg   = seg_q;
      cur_off   = off_q;
      cur_tok   = tok_q;
      cur_left  = left_q;
      cur_idx   = idx_q;
      cur_mlen  = mlen_q;
      cur_hib   = hib_q;
      cur_reloc = reloc_q;
    end
  end

  always_comb begin
    logic             run_al;
    logic             run_ac;
    logic             run_copy;
    logic [LenW-1:0]  idx_nx;
    logic [AddrW:0]   seg_delta;
    logic [DataW-1:0] thr;
    logic [DataW-1:0] b_inc;
    result_t          cp;

    phase_d   = cur_phase;
    waddr_d   = cur_waddr;
    seg_d     = cur_seg;
    off_d     = cur_off;
    tok_d     = cur_tok;
    left_d    = cur_left;
    idx_d     = cur_idx;
    mlen_d    = cur_mlen;
    hib_d     = cur_hib;
    reloc_d   = cur_reloc;
    run_al    = 1'b0;
    run_ac    = 1'b0;
    run_copy  = 1'b0;
    idx_nx    = cur_idx + LenW'(1);
    seg_delta = {1'b0, cur_waddr} - {1'b0, cur_seg};
    b_inc     = byte_i + DataW'(1);
    thr       = '0;
    cp        = '0;
    step_o    = '0;

    case (cur_phase)
      PH_MAGIC0: begin
        if (byte_i == '0) phase_d = PH_MAGIC1;
        else begin
          phase_d          = PH_ERROR;
          step_o.count     = 2'd1;
          step_o.r0.kind   = KIND_BAD;
        end
      end
      PH_MAGIC1: begin
        if (byte_i == 8'hff) phase_d = PH_SEGHI;
        else begin
          phase_d          = PH_ERROR;
          step_o.count     = 2'd1;
          step_o.r0.kind   = KIND_BAD;
        end
      end
      PH_SEGHI: begin
        hib_d   = byte_i;
        phase_d = PH_SEGLO;
      end
      PH_SEGLO: begin
        waddr_d = {cur_hib, byte_i};
        seg_d   = {cur_hib, byte_i};
        phase_d = PH_TOKEN;
      end
      PH_TOKEN: begin
        tok_d = byte_i;
        if (byte_i[6:4] == 3'd7) phase_d = PH_LITCNT;
        else if (byte_i[6:4] != 3'd0) begin
          left_d  = LenW'(byte_i[6:4]);
          idx_d   = '0;
          phase_d = PH_LITS;
        end else run_al = 1'b1;
      end
      PH_LITCNT: begin
        left_d  = (byte_i == '0) ? LenW'(256) : LenW'(byte_i);
        idx_d   = '0;
        phase_d = PH_LITS;
      end
      PH_LITS: begin
        step_o.count   = 2'd1;
        step_o.r0.kind = KIND_LIT;
        step_o.r0.dest = cur_waddr + AddrW'(cur_idx);
        step_o.r0.data = byte_i;
        idx_d          = idx_nx;
        if (cur_left <= LenW'(1)) begin
          left_d  = '0;
          waddr_d = {cur_waddr[15:8], cur_waddr[7:0] + idx_nx[7:0]};
          run_al  = 1'b1;
        end else left_d = cur_left - LenW'(1);
      end
      PH_MCNT: begin
        mlen_d = (byte_i == '0) ? LenW'(256) : LenW'(byte_i);
        run_ac = 1'b1;
      end
      PH_OFFHI: begin
        if (byte_i[7]) begin
          // short offset, page relative; threshold from distance into the segment
          if (seg_delta[AddrW]) thr = '0;
          else if (seg_delta[AddrW-1:7] != '0) thr = 8'hff;
          else thr = {1'b1, seg_delta[6:0]};
          if (byte_i < thr) off_d = AddrW'(b_inc[6:0]);
          else off_d = {7'd0, 1'b1, b_inc};
          run_copy = 1'b1;
        end else begin
          hib_d   = byte_i;
          phase_d = PH_OFFLO;
        end
      end
      PH_OFFLO: begin
        off_d    = {cur_hib, byte_i};
        run_copy = 1'b1;
      end
      PH_LSEGHI: begin
        if (byte_i == '0) phase_d = PH_EXECHI;
        else begin
          hib_d   = byte_i;
          phase_d = PH_LSEGLO;
        end
      end
      PH_LSEGLO: begin
        waddr_d = {cur_hib, byte_i};
        seg_d   = {cur_hib, byte_i};
        reloc_d = 1'b0;
        phase_d = PH_TOKEN;
      end
      PH_EXECHI: begin
        hib_d   = byte_i;
        phase_d = PH_EXECLO;
      end
      PH_EXECLO: begin
        step_o.count    = 2'd1;
        step_o.r0.kind  = KIND_END;
        step_o.r0.dest  = {cur_hib, byte_i};
        step_o.r0.reloc = cur_reloc;
        phase_d         = PH_DONE;
      end
      PH_ERROR: begin
        step_o.count   = 2'd1;
        step_o.r0.kind = KIND_BAD;
      end
      PH_DONE: ;
      default: ;
    endcase

    // end of literal run: pick up the match count from the token
    if (run_al) begin
      if (tok_d[3:0] == 4'hf) phase_d = PH_MCNT;
      else begin
        mlen_d = (tok_d[3:0] == 4'h0) ? '0 : LenW'(tok_d[3:0]) + LenW'(1);
        run_ac = 1'b1;
      end
    end

    if (run_ac) begin
      if (mlen_d != '0) begin
        if (tok_d[7]) phase_d = PH_OFFHI;
        else run_copy = 1'b1;
      end else if (tok_d[7]) begin
        seg_d   = cur_seg + AddrW'(256);
        waddr_d = cur_seg + AddrW'(256);
        phase_d = PH_TOKEN;
      end else phase_d = PH_LSEGHI;
    end

    if (run_copy) begin
      cp.kind = KIND_COPY;
      cp.dest = waddr_d;
      cp.src  = {waddr_d[15:8] - off_d[15:8], waddr_d[7:0] - off_d[7:0]};
      cp.len  = mlen_d;
      waddr_d = {waddr_d[15:8], waddr_d[7:0] + mlen_d[7:0]};
      phase_d = PH_TOKEN;
      if (step_o.count == 2'd0) begin
        step_o.r0    = cp;
        step_o.count = 2'd1;
      end else begin
        step_o.r1    = cp;
        step_o.count = 2'd2;
      end
    end

    step_o.r0.last = (step_o.count == 2'd1);
    step_o.r1.last = (step_o.count == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC0;
      waddr_q <= '0;
      seg_q   <= '0;
      off_q   <= AddrW'(1);
      tok_q   <= '0;
      left_q  <= '0;
      idx_q   <= '0;
      mlen_q  <= '0;
      hib_q   <= '0;
      reloc_q <= 1'b1;
    end else if (fire_i) begin
      phase_q <= phase_d;
      waddr_q <= waddr_d;
      seg_q   <= seg_d;
      off_q   <= off_d;
      tok_q   <= tok_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
      mlen_q  <= mlen_d;
      hib_q   <= hib_d;
      reloc_q <= reloc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lzpid_result_fifo.sv
// small result queue taking up to two results per cycle, one out per cycle while the reader is ready
`default_nettype none

module lzpid_result_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire lzpid_pkg::step_t     step_i,
  output logic                      room_o,
  output logic                      valid_o,
  input  wire logic                 pop_ready_i,
  output lzpid_pkg::result_t        result_o,
  output lzpid_pkg::fifo_status_t   status_o
);
  import lzpid_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoCntW-1:0] n_push;
  logic                pop;

  assign n_push   = push_i ? FifoCntW'(step_i.count) : '0;
  assign valid_o  = (cnt_q != '0);
  assign pop      = valid_o && pop_ready_i;
  // room for a worst-case byte
  assign room_o   = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign result_o = mem_q[rp_q];
  assign status_o.count = cnt_q;

  assign wp_d  = wp_q + FifoPtrW'(n_push);
  assign rp_d  = rp_q + FifoPtrW'(pop);
  assign cnt_d = cnt_q + n_push - FifoCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != '0) mem_q[wp_q] <= step_i.r0;
    if (n_push == FifoCntW'(2)) mem_q[wp_q + FifoPtrW'(1)] <= step_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lz_paged_image_decoder.sv
// top level of the paged lz memory image stream decoder
//
//  channel  dir  tdata                                   tuser            tlast
//  s_axis   in   [7:0] stream byte                       start of stream  -
//  m_axis   out  dest, data, src, copy_len, relocatable  kind             last of byte
//
// one byte per cycle while the queue has room; the parse step is one combinational
// pass from the phase registers into the result queue, which registers the results
// a byte gives at most two results (last literal plus copy); the queue drains
// one per cycle, so a stalled output holds off input once three results wait
// asynchronous active-low reset puts the parser at the first magic byte
`default_nettype none

module lz_paged_image_decoder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,  // [7:0] stream_byte
  input  wire logic                           s_axis_tuser_i,  // [0] start_of_stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [15:0] dest_addr, [23:16] data_byte, [39:24] src_addr, [48:40] copy_len,
  // [49] relocatable, [55:50] zero
  output logic [lzpid_pkg::TdataW-1:0]        m_axis_tdata_o,
  output logic [1:0]                          m_axis_tuser_o,  // [1:0] kind
  output logic                                m_axis_tlast_o
);
  import lzpid_pkg::*;

  logic         in_fire;
  step_t        step;
  result_t      res;
  fifo_status_t fstat;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  lzpid_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .byte_i  (s_axis_tdata_i),
    .start_i (s_axis_tuser_i),
    .step_o  (step)
  );

  lzpid_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .step_i      (step),
    .room_o      (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .result_o    (res),
    .status_o    (fstat)
  );

  assign m_axis_tdata_o = {6'd0, res.reloc, res.len, res.src, res.data, res.dest};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

  // queue never holds more than its depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  // a byte with results makes the output valid next cycle
  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && step.count != 2'd0 |=> m_axis_tvalid_o)
    else $error("accepted results not presented");

  // two results per byte only as last literal followed by a copy
  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && step.count == 2'd2 |->
      step.r0.kind == KIND_LIT && step.r1.kind == KIND_COPY && !step.r0.last)
    else $error("bad result pair");

endmodule

`default_nettype wire

>>> tb/lz_paged_image_decoder_tb.sv
// self-checking testbench for the paged lz image decoder: directed table, then random streams
`default_nettype none

module lz_paged_image_decoder_tb;
  import lzpid_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int STREAM_BYTES = 950;
  localparam int DRAIN_CYCLES = 20;

  // one stream byte; typed rows carry their single expected result
  typedef struct packed {
    logic [7:0]  b;
    logic        sos;
    logic        typed;
    kind_e       kind;
    logic [15:0] dest;
    logic        reloc;
  } stim_row_t;

  localparam int N_DIRECTED = 28;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h01, 1'b1, 1'b1, KIND_BAD, 16'h0000, 1'b0},  // bad first magic byte
    '{8'h55, 1'b0, 1'b1, KIND_BAD, 16'h0000, 1'b0},  // error is sticky
    '{8'h00, 1'b1, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // restart, good magic
    '{8'hff, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h12, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // segment 0x1234
    '{8'h34, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h21, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // 2 literals, copy 2, old offset
    '{8'haa, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h55, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // last literal plus copy
    '{8'hff, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // extra literal and match counts
    '{8'h01, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // match count 256
    '{8'h85, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // short offset at threshold
    '{8'h8e, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h12, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // long offset
    '{8'h34, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // next page
    '{8'h00, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // long segment header
    '{8'hff, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'hff, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h20, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // literals wrap past 0xffff
    '{8'h11, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h22, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},  // end marker
    '{8'hff, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0},
    '{8'hff, 1'b0, 1'b1, KIND_END, 16'hffff, 1'b0},  // exec 0xffff, not relocatable
    '{8'h3c, 1'b0, 1'b0, KIND_LIT, 16'h0000, 1'b0}   // ignored after end
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [TdataW-1:0]   m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;

  lz_paged_image_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  stim_row_t stim_rows [$];
  result_t   pending_mem_ops [$];
  result_t   step_ops [$];
  int        counted_bytes;
  int        accepted_bytes;
  int        mismatch_count;
  int        cycle_count;

  // parser mirror
  phase_e      ph;
  logic [15:0] wr_addr;
  logic [15:0] seg_base;
  logic [15:0] offset;
  logic [7:0]  token;
  logic [7:0]  held_hi;
  logic [8:0]  lits_left;
  logic [8:0]  lit_idx;
  logic [8:0]  mlen;
  logic        reloc;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %0s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic parser_reset();
    ph        = PH_MAGIC0;
    wr_addr   = '0;
    seg_base  = '0;
    offset    = 16'd1;
    token     = '0;
    lits_left = '0;
    lit_idx   = '0;
    mlen      = '0;
    held_hi   = '0;
    reloc     = 1'b1;
  endtask

  task automatic emit_op(input kind_e k, input logic [15:0] dest, input logic [7:0] data,
                         input logic [15:0] src, input logic [8:0] len, input logic rel);
    result_t r;
    r       = '0;
    r.kind  = k;
    r.dest  = dest;
    r.data  = data;
    r.src   = src;
    r.len   = len;
    r.reloc = rel;
    step_ops.insert(step_ops.size(), r);
  endtask

  task automatic issue_copy();
    logic [15:0] src;
    // byte-wise subtract, no borrow from low to high byte
    src = {wr_addr[15:8] - offset[15:8], wr_addr[7:0] - offset[7:0]};
    emit_op(KIND_COPY, wr_addr, 8'h00, src, mlen, 1'b0);
    wr_addr[7:0] = wr_addr[7:0] + mlen[7:0];
    ph = PH_TOKEN;
  endtask

  task automatic match_count_known();
    if (mlen != 0) begin
      if (token[7]) ph = PH_OFFHI;
      else issue_copy();
    end else if (token[7]) begin
      seg_base = seg_base + 16'h0100;
      wr_addr  = seg_base;
      ph       = PH_TOKEN;
    end else begin
      ph = PH_LSEGHI;
    end
  endtask

  task automatic literals_done();
    if (token[3:0] == 4'hf) begin
      ph = PH_MCNT;
    end else begin
      mlen = (token[3:0] != 0) ? 9'(token[3:0]) + 9'd1 : 9'd0;
      match_count_known();
    end
  endtask

  // expected results of one accepted stream byte, left in step_ops
  task automatic parse_stream_byte(input logic [7:0] b, input logic sos);
    int      dist_in_seg;
    int      thr;
    int      bi;
    step_ops.delete();
    if (sos) parser_reset();
    bi = b;
    case (ph)
      PH_MAGIC0: begin
        if (b == 8'h00) ph = PH_MAGIC1;
        else begin
          ph = PH_ERROR;
          emit_op(KIND_BAD, 16'h0, 8'h0, 16'h0, 9'h0, 1'b0);
        end
      end
      PH_MAGIC1: begin
        if (b == 8'hff) ph = PH_SEGHI;
        else begin
          ph = PH_ERROR;
          emit_op(KIND_BAD, 16'h0, 8'h0, 16'h0, 9'h0, 1'b0);
        end
      end
      PH_SEGHI: begin
        held_hi = b;
        ph      = PH_SEGLO;
      end
      PH_SEGLO: begin
        seg_base = {held_hi, b};
        wr_addr  = seg_base;
        ph       = PH_TOKEN;
      end
      PH_TOKEN: begin
        token = b;
        if (b[6:4] == 3'd7) begin
          ph = PH_LITCNT;
        end else if (b[6:4] != 3'd0) begin
          lits_left = 9'(b[6:4]);
          lit_idx   = '0;
          ph        = PH_LITS;
        end else begin
          literals_done();
        end
      end
      PH_LITCNT: begin
        lits_left = (b != 0) ? 9'(b) : 9'd256;
        lit_idx   = '0;
        ph        = PH_LITS;
      end
      PH_LITS: begin
        emit_op(KIND_LIT, wr_addr + 16'(lit_idx), b, 16'h0, 9'h0, 1'b0);
        lit_idx = lit_idx + 9'd1;
        if (lits_left <= 1) begin
          lits_left    = '0;
          wr_addr[7:0] = wr_addr[7:0] + lit_idx[7:0];
          literals_done();
        end else begin
          lits_left = lits_left - 9'd1;
        end
      end
      PH_MCNT: begin
        mlen = (b != 0) ? 9'(b) : 9'd256;
        match_count_known();
      end
      PH_OFFHI: begin
        if (b[7]) begin
          // page-relative short offset; the threshold depends on how far into the segment
          dist_in_seg = int'(wr_addr) - int'(seg_base);
          if (dist_in_seg < 0) thr = 0;
          else if (dist_in_seg > 'h7f) thr = 'hff;
          else thr = dist_in_seg | 'h80;
          if (bi < thr) offset = 16'((bi + 1) & 'h7f);
          else offset = 16'(256 + ((bi + 1) & 'hff));
          issue_copy();
        end else begin
          held_hi = b;
          ph      = PH_OFFLO;
        end
      end
      PH_OFFLO: begin
        offset = {held_hi, b};
        issue_copy();
      end
      PH_LSEGHI: begin
        if (b == 8'h00) ph = PH_EXECHI;
        else begin
          held_hi = b;
          ph      = PH_LSEGLO;
        end
      end
      PH_LSEGLO: begin
        seg_base = {held_hi, b};
        wr_addr  = seg_base;
        reloc    = 1'b0;
        ph       = PH_TOKEN;
      end
      PH_EXECHI: begin
        held_hi = b;
        ph      = PH_EXECLO;
      end
      PH_EXECLO: begin
        emit_op(KIND_END, {held_hi, b}, 8'h0, 16'h0, 9'h0, reloc);
        ph = PH_DONE;
      end
      PH_ERROR: emit_op(KIND_BAD, 16'h0, 8'h0, 16'h0, 9'h0, 1'b0);
      default: ;
    endcase
    if (step_ops.size() > 0) step_ops[step_ops.size() - 1].last = 1'b1;
  endtask

  // stream building

  task automatic put_byte(input logic [7:0] b, input logic sos, input bit counted);
    stim_row_t row;
    row       = '0;
    row.b     = b;
    row.sos   = sos;
    row.typed = 1'b0;
    row.kind  = KIND_LIT;
    stim_rows.insert(stim_rows.size(), row);
    if (counted) counted_bytes++;
  endtask

  task automatic put_token(input bit dir, input int lf, input int mf);
    int nlit;
    int k;
    put_byte({dir, lf[2:0], mf[3:0]}, 1'b0, 1'b1);
    nlit = lf;
    if (lf == 7) begin
      // a full 256-byte literal run only now and then
      if ($urandom_range(0, 149) == 0) nlit = 256;
      else nlit = $urandom_range(1, 20);
      put_byte(nlit[7:0], 1'b0, 1'b1);
    end
    for (k = 0; k < nlit; k++) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    if (mf == 15) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic gen_stream();
    int sel;
    int ntok;
    int pick;
    int k;
    int mf;
    bit dir;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      // noise, mostly a broken magic
      put_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      repeat ($urandom_range(0, 7))
        put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
    end else begin
      put_byte(8'h00, 1'b1, 1'b1);
      put_byte(8'hff, 1'b0, 1'b1);
      put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      ntok = $urandom_range(1, 10);
      for (k = 0; k < ntok; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          mf  = 0;
          dir = 1'b1;
        end else if (pick == 2) begin
          mf  = 0;
          dir = 1'b0;
        end else begin
          mf  = $urandom_range(1, 15);
          dir = $urandom_range(0, 1);
        end
        put_token(dir, $urandom_range(0, 7), mf);
        if (pick == 2) begin
          // long segment header, high byte nonzero
          put_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
          put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else if (mf != 0 && dir) begin
          if ($urandom_range(0, 1)) begin
            put_byte(8'h80 | 8'($urandom_range(0, 255)), 1'b0, 1'b1);
          end else begin
            put_byte(8'($urandom_range(0, 127)), 1'b0, 1'b1);
            put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          end
        end
      end
      // some streams are cut short
      if ($urandom_range(0, 9) != 0) begin
        put_token(1'b0, $urandom_range(0, 7), 0);
        put_byte(8'h00, 1'b0, 1'b1);
        put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end
  endtask

  // gap before the next transaction, with runs of back-to-back traffic
  task automatic draw_gap(inout int run, output int gap);
    if (run == 0 && $urandom_range(0, 7) == 0) run = $urandom_range(10, 40);
    if (run > 0) begin
      run--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 6);
    end
  endtask

  // checker: input side first so a same-edge result already has its expectation
  always @(posedge clk_i) begin
    stim_row_t row;
    result_t   want;
    result_t   got;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        row = stim_rows[accepted_bytes];
        accepted_bytes++;
        parse_stream_byte(s_tdata, s_tuser);
        if (row.typed) begin
          want       = '0;
          want.kind  = row.kind;
          want.dest  = row.dest;
          want.reloc = row.reloc;
          want.last  = 1'b1;
          pending_mem_ops.insert(pending_mem_ops.size(), want);
        end else begin
          foreach (step_ops[i]) pending_mem_ops.insert(pending_mem_ops.size(), step_ops[i]);
        end
      end
      if (m_tvalid && m_tready) begin
        got.kind  = kind_e'(m_tuser);
        got.dest  = m_tdata[15:0];
        got.data  = m_tdata[23:16];
        got.src   = m_tdata[39:24];
        got.len   = m_tdata[48:40];
        got.reloc = m_tdata[49];
        got.last  = m_tlast;
        if (pending_mem_ops.size() == 0) begin
          report_mismatch("unexpected transaction, dest", got.dest, 16'h0);
        end else begin
          want = pending_mem_ops.pop_front();
          if (got.kind != want.kind) report_mismatch("kind", 16'(got.kind), 16'(want.kind));
          if (got.dest != want.dest) report_mismatch("dest_addr", got.dest, want.dest);
          if (got.data != want.data) report_mismatch("data_byte", 16'(got.data), 16'(want.data));
          if (got.src != want.src) report_mismatch("src_addr", got.src, want.src);
          if (got.len != want.len) report_mismatch("copy_len", 16'(got.len), 16'(want.len));
          if (got.reloc != want.reloc)
            report_mismatch("relocatable", 16'(got.reloc), 16'(want.reloc));
          if (got.last != want.last) report_mismatch("last", 16'(got.last), 16'(want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lz_paged_image_decoder verification failed");
      $finish;
    end
  end

  // result sink with random back-pressure
  initial begin
    int run;
    int gap;
    run      = 0;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      draw_gap(run, gap);
      if (gap > 0) begin
        @(negedge clk_i) m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  initial begin
    int run;
    int gap;
    int idx;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    rst_ni         = 1'b0;
    run            = 0;
    counted_bytes  = 0;
    accepted_bytes = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    parser_reset();
    for (idx = 0; idx < N_DIRECTED; idx++) stim_rows.insert(stim_rows.size(), DIRECTED[idx]);
    while (counted_bytes < STREAM_BYTES) gen_stream();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (idx = 0; idx < stim_rows.size(); idx++) begin
      draw_gap(run, gap);
      if (gap > 0) begin
        @(negedge clk_i) s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      s_tvalid <= 1'b1;
      s_tdata  <= stim_rows[idx].b;
      s_tuser  <= stim_rows[idx].sos;
      do @(posedge clk_i); while (!(s_tvalid && s_tready));
    end
    @(negedge clk_i) s_tvalid <= 1'b0;

    while (pending_mem_ops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_mem_ops.size() == 0) begin
      $display("lz_paged_image_decoder verification clean");
    end else begin
      $display("lz_paged_image_decoder verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
